FILE: sv/assert_macros.svh
// Assertion macros used by the top RTL file of the code converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CCC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define CCC_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`endif

FILE: sv/ccc_pkg.sv
// Types and constants shared by the character code converter modules.
package ccc_pkg;

    localparam logic [15:0] MISSING_RESET = 16'hfffd;
    localparam int          BYTE_DEPTH    = 256;
    localparam logic [15:0] WIDE_BASE     = 16'h0100;

    localparam int          CFG_IDX_W  = 3;
    localparam int          CFG_DATA_W = 16;
    localparam logic [2:0]  CFG_LEAD_LOW   = 3'd0;
    localparam logic [2:0]  CFG_LEAD_HIGH  = 3'd1;
    localparam logic [2:0]  CFG_TRAIL_LOW  = 3'd2;
    localparam logic [2:0]  CFG_TRAIL_HIGH = 3'd3;
    localparam logic [2:0]  CFG_MISSING    = 3'd4;

    // queue depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        TAG_B8   = 2'd0,
        TAG_WIDE = 2'd1,
        TAG_ERR  = 2'd2
    } tag_t;

    typedef enum logic [2:0] {
        CMD_CONVERT = 3'd0,
        CMD_WR_BYTE = 3'd1,
        CMD_WR_WIDE = 3'd2,
        CMD_ADD_OVR = 3'd3,
        CMD_CLR_OVR = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_PASS      = 3'd0,
        OP_LOOK_BYTE = 3'd1,
        OP_LOOK_WIDE = 3'd2,
        OP_WR_BYTE   = 3'd3,
        OP_WR_WIDE   = 3'd4
    } op_t;

    typedef struct packed {
        logic [7:0]  lead_low;
        logic [7:0]  lead_high;
        logic [7:0]  trail_low;
        logic [7:0]  trail_high;
        logic [15:0] missing_marker;
    } cfg_t;

    typedef struct packed {
        tag_t        out_type;
        logic [15:0] out_value;
        status_t     status;
    } result_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] index;
        logic [15:0] data;
        result_t     res;
    } back_op_t;

    // tag code 3 counts as error
    function automatic tag_t norm_tag(input logic [1:0] t);
        norm_tag = (t > 2'(TAG_ERR)) ? TAG_ERR : tag_t'(t);
    endfunction

endpackage

FILE: sv/ccc_ram.sv
// Generic simple dual-port RAM with registered read.
module ccc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/ccc_queue.sv
// Small register queue between the front and back parts.
module ccc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  ccc_pkg::back_op_t  push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output ccc_pkg::back_op_t  pop_data
);

    ccc_pkg::back_op_t                 entry_reg [ccc_pkg::QUEUE_DEPTH];
    logic [ccc_pkg::QPTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [ccc_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;
    logic                              push, pop;

    assign push_ready = (cnt_reg != ccc_pkg::QCNT_W'(ccc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/ccc_front.sv
// Front part: accepts items, searches overrides, checks ranges, builds back ops.
module ccc_front #(
    parameter int MAX_OVERRIDES = 16,
    parameter int MAX_ROWS      = 128,
    parameter int MAX_COLS      = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  ccc_pkg::cfg_t      cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [2:0]         command,
    input  logic [1:0]         in_type,
    input  logic [15:0]        in_value,
    input  logic               wide_only,
    input  logic [1:0]         map_type,
    input  logic [15:0]        map_value,
    output logic               q_push_valid,
    input  logic               q_push_ready,
    output ccc_pkg::back_op_t  q_push_data
);

    localparam int CNT_W  = $clog2(MAX_OVERRIDES + 1);
    localparam int OIDX_W = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;

    logic [17:0]        src_reg [MAX_OVERRIDES];
    logic [17:0]        tgt_reg [MAX_OVERRIDES];
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    ccc_pkg::tag_t      tag, mtag;
    logic [17:0]        key;
    logic               hit;
    logic [17:0]        hit_tgt;
    logic [7:0]         lead, trail, row, col;
    logic               in_rng;
    logic [15:0]        wide_idx;
    logic               accept, ovr_add, ovr_clr;
    ccc_pkg::back_op_t  op;
    ccc_pkg::result_t   err_res;

    assign s_tready     = en && q_push_ready;
    assign accept       = s_tvalid && s_tready;
    assign q_push_valid = accept;
    assign q_push_data  = op;

    assign tag     = ccc_pkg::norm_tag(in_type);
    assign mtag    = ccc_pkg::norm_tag(map_type);
    assign key     = {tag, in_value};
    assign err_res = '{out_type: ccc_pkg::TAG_ERR, out_value: 16'd0, status: ccc_pkg::ST_OK};

    // earliest match wins
    always_comb begin
        hit     = 1'b0;
        hit_tgt = '0;
        for (int i = MAX_OVERRIDES - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < cnt_reg) && (src_reg[i] == key)) begin
                hit     = 1'b1;
                hit_tgt = tgt_reg[i];
            end
        end
    end

    assign lead     = in_value[15:8];
    assign trail    = in_value[7:0];
    assign row      = lead - cfg.lead_low;
    assign col      = trail - cfg.trail_low;
    assign in_rng   = (lead >= cfg.lead_low) && (lead <= cfg.lead_high)
                   && (trail >= cfg.trail_low) && (trail <= cfg.trail_high)
                   && ({1'b0, row} < 9'(MAX_ROWS)) && ({1'b0, col} < 9'(MAX_COLS));
    assign wide_idx = 16'(row) * 16'(MAX_COLS) + 16'(col);

    always_comb begin
        op      = '{op: ccc_pkg::OP_PASS, index: in_value, data: map_value,
                    res: '{out_type: ccc_pkg::TAG_B8, out_value: 16'd0,
                           status: ccc_pkg::ST_OK}};
        ovr_add = 1'b0;
        ovr_clr = 1'b0;
        unique case (command)
            ccc_pkg::CMD_CONVERT: begin
                if (hit) begin
                    op.res = '{out_type: ccc_pkg::tag_t'(hit_tgt[17:16]),
                               out_value: hit_tgt[15:0], status: ccc_pkg::ST_OK};
                end else if (tag == ccc_pkg::TAG_B8 && !wide_only) begin
                    if (lead != 8'd0) begin
                        op.res = err_res;
                    end else begin
                        op.op = ccc_pkg::OP_LOOK_BYTE;
                    end
                end else if (tag == ccc_pkg::TAG_WIDE) begin
                    if (in_rng) begin
                        op.op    = ccc_pkg::OP_LOOK_WIDE;
                        op.index = wide_idx;
                    end else begin
                        op.res = err_res;
                    end
                end else begin
                    op.res = err_res;
                end
            end
            ccc_pkg::CMD_WR_BYTE: begin
                if (lead != 8'd0) begin
                    op.res.status = ccc_pkg::ST_RANGE;
                end else begin
                    op.op = ccc_pkg::OP_WR_BYTE;
                end
            end
            ccc_pkg::CMD_WR_WIDE: begin
                if (in_rng) begin
                    op.op    = ccc_pkg::OP_WR_WIDE;
                    op.index = wide_idx;
                end else begin
                    op.res.status = ccc_pkg::ST_RANGE;
                end
            end
            ccc_pkg::CMD_ADD_OVR: begin
                if (cnt_reg == CNT_W'(MAX_OVERRIDES)) begin
                    op.res.status = ccc_pkg::ST_FULL;
                end else begin
                    ovr_add = 1'b1;
                end
            end
            ccc_pkg::CMD_CLR_OVR: begin
                ovr_clr = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (accept && ovr_clr) begin
            cnt_next = '0;
        end else if (accept && ovr_add) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && ovr_add) begin
            src_reg[cnt_reg[OIDX_W-1:0]] <= key;
            tgt_reg[cnt_reg[OIDX_W-1:0]] <= {mtag, map_value};
        end
    end

endmodule

FILE: sv/ccc_back.sv
// Back part: clears the wide table, runs table reads and writes, holds the result.
module ccc_back #(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ccc_pkg::cfg_t      cfg,
    output logic               clearing,
    input  logic               q_pop_valid,
    output logic               q_pop_ready,
    input  ccc_pkg::back_op_t  q_pop_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output ccc_pkg::result_t   m_res
);

    localparam int WDEPTH = MAX_ROWS * MAX_COLS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    logic                                clr_active_reg;
    logic [WAW-1:0]                      clr_addr_reg;
    logic [ccc_pkg::BYTE_DEPTH-1:0]      bvld_reg;
    logic                                b_vld_reg, b_vld_next;
    ccc_pkg::op_t                        b_op_reg;
    ccc_pkg::result_t                    b_res_reg;
    logic                                b_bvld_reg;
    logic                                m_tvalid_reg, m_tvalid_next;
    ccc_pkg::result_t                    m_res_reg;

    logic               pop, b_adv;
    logic [7:0]         byte_addr;
    logic [15:0]        byte_rd, wide_rd, look_val;
    logic               wide_we;
    logic [WAW-1:0]     wide_waddr;
    logic [15:0]        wide_wdata;
    ccc_pkg::result_t   b_res;

    assign clearing    = clr_active_reg;
    assign b_adv       = b_vld_reg && (!m_tvalid_reg || m_tready);
    assign q_pop_ready = !clr_active_reg && (!b_vld_reg || b_adv);
    assign pop         = q_pop_valid && q_pop_ready;
    assign byte_addr   = q_pop_data.index[7:0];

    ccc_ram #(
        .WIDTH (16),
        .DEPTH (ccc_pkg::BYTE_DEPTH)
    ) u_byte_ram (
        .aclk    (aclk),
        .wr_en   (pop && q_pop_data.op == ccc_pkg::OP_WR_BYTE),
        .wr_addr (byte_addr),
        .wr_data (q_pop_data.data),
        .rd_en   (pop && q_pop_data.op == ccc_pkg::OP_LOOK_BYTE),
        .rd_addr (byte_addr),
        .rd_data (byte_rd)
    );

    assign wide_we    = clr_active_reg || (pop && q_pop_data.op == ccc_pkg::OP_WR_WIDE);
    assign wide_waddr = clr_active_reg ? clr_addr_reg : q_pop_data.index[WAW-1:0];
    assign wide_wdata = clr_active_reg ? ccc_pkg::MISSING_RESET : q_pop_data.data;

    ccc_ram #(
        .WIDTH (16),
        .DEPTH (WDEPTH)
    ) u_wide_ram (
        .aclk    (aclk),
        .wr_en   (wide_we),
        .wr_addr (wide_waddr),
        .wr_data (wide_wdata),
        .rd_en   (pop && q_pop_data.op == ccc_pkg::OP_LOOK_WIDE),
        .rd_addr (q_pop_data.index[WAW-1:0]),
        .rd_data (wide_rd)
    );

    // unwritten byte entries read as the reset marker
    assign look_val = (b_op_reg == ccc_pkg::OP_LOOK_BYTE)
                    ? (b_bvld_reg ? byte_rd : ccc_pkg::MISSING_RESET) : wide_rd;

    always_comb begin
        b_res = b_res_reg;
        if (b_op_reg == ccc_pkg::OP_LOOK_BYTE || b_op_reg == ccc_pkg::OP_LOOK_WIDE) begin
            if (look_val == cfg.missing_marker) begin
                b_res = '{out_type: ccc_pkg::TAG_ERR, out_value: 16'd0,
                          status: ccc_pkg::ST_OK};
            end else begin
                b_res = '{out_type: (look_val < ccc_pkg::WIDE_BASE) ? ccc_pkg::TAG_B8
                                                                     : ccc_pkg::TAG_WIDE,
                          out_value: look_val, status: ccc_pkg::ST_OK};
            end
        end
    end

    assign b_vld_next    = pop ? 1'b1 : (b_adv ? 1'b0 : b_vld_reg);
    assign m_tvalid_next = b_adv ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            bvld_reg       <= '0;
            b_vld_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == WAW'(WDEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (pop && q_pop_data.op == ccc_pkg::OP_WR_BYTE) begin
                bvld_reg[byte_addr] <= 1'b1;
            end
            b_vld_reg    <= b_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b_op_reg   <= q_pop_data.op;
            b_res_reg  <= q_pop_data.res;
            b_bvld_reg <= bvld_reg[byte_addr];
        end
        if (b_adv) begin
            m_res_reg <= b_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_res    = m_res_reg;

endmodule

FILE: sv/charset_code_converter_top.sv
// Items pass the queue, the back stage and the output register; one item per cycle while m_tready is high.
// Front registers ops into a 2-entry queue; back reads the table RAMs then loads the output.
// Reset: synchronous, active-low aresetn clears control, overrides and byte table valid bits.
// After reset the wide table is swept to 0xfffd, one entry per cycle, over all MAX_ROWS*MAX_COLS
// entries (32768 by default); s_tready stays low during the sweep, config writes still taken.
`include "assert_macros.svh"

module charset_code_converter_top #(
    parameter int MAX_OVERRIDES = 16,
    parameter int MAX_ROWS      = 128,
    parameter int MAX_COLS      = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // command[2:0], in_value[18:3], wide_only[19], map_value[35:20], zero pad
    input  logic [39:0]                       s_tdata,
    // in_type[1:0], map_type[3:2]
    input  logic [3:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_value[15:0], status[17:16], zero pad
    output logic [23:0]                       m_tdata,
    // out_type[1:0]
    output logic [1:0]                        m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [ccc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccc_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    ccc_pkg::cfg_t      cfg_reg;
    logic               clearing;
    logic               front_ready;
    logic               q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    ccc_pkg::back_op_t  q_push_data, q_pop_data;
    ccc_pkg::result_t   m_res;
    logic               m_status_set, m_res_clear;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{lead_low: 8'h00, lead_high: 8'hff, trail_low: 8'h00,
                         trail_high: 8'hff, missing_marker: ccc_pkg::MISSING_RESET};
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ccc_pkg::CFG_LEAD_LOW:   cfg_reg.lead_low       <= cfg_wr_data[7:0];
                ccc_pkg::CFG_LEAD_HIGH:  cfg_reg.lead_high      <= cfg_wr_data[7:0];
                ccc_pkg::CFG_TRAIL_LOW:  cfg_reg.trail_low      <= cfg_wr_data[7:0];
                ccc_pkg::CFG_TRAIL_HIGH: cfg_reg.trail_high     <= cfg_wr_data[7:0];
                ccc_pkg::CFG_MISSING:    cfg_reg.missing_marker <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    ccc_front #(
        .MAX_OVERRIDES (MAX_OVERRIDES),
        .MAX_ROWS      (MAX_ROWS),
        .MAX_COLS      (MAX_COLS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (!clearing),
        .cfg          (cfg_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (front_ready),
        .command      (s_tdata[2:0]),
        .in_type      (s_tuser[1:0]),
        .in_value     (s_tdata[18:3]),
        .wide_only    (s_tdata[19]),
        .map_type     (s_tuser[3:2]),
        .map_value    (s_tdata[35:20]),
        .q_push_valid (q_push_valid),
        .q_push_ready (q_push_ready),
        .q_push_data  (q_push_data)
    );

    ccc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    ccc_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .clearing    (clearing),
        .q_pop_valid (q_pop_valid),
        .q_pop_ready (q_pop_ready),
        .q_pop_data  (q_pop_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_res       (m_res)
    );

    assign s_tready = front_ready;
    assign m_tdata  = {6'd0, m_res.status, m_res.out_value};
    assign m_tuser  = m_res.out_type;

    assign m_status_set = m_tvalid && (m_res.status != ccc_pkg::ST_OK);
    assign m_res_clear  = (m_res.out_value == 16'd0) && (m_res.out_type == ccc_pkg::TAG_B8);

    `CCC_ASSERT(a_status_no_code, aclk, aresetn, m_status_set |-> m_res_clear, "status item has data")
    `CCC_ASSERT(a_no_accept_clear, aclk, aresetn, clearing |-> !s_tready, "ready during table clear")
    `CCC_NEVER(a_queue_overflow, aclk, aresetn, q_push_valid && !q_push_ready, "push into full queue")

endmodule

FILE: sim/charset_code_checker.sv
// Checker for the charset code converter: predicts each result from the accepted items and compares.
module charset_code_checker #(
    parameter int MAX_OVERRIDES = 16,
    parameter int MAX_ROWS      = 128,
    parameter int MAX_COLS      = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // command[2:0], in_value[18:3], wide_only[19], map_value[35:20], zero pad
    input  logic [39:0]                        s_tdata,
    // in_type[1:0], map_type[3:2]
    input  logic [3:0]                         s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // out_value[15:0], status[17:16], zero pad
    input  logic [23:0]                        m_tdata,
    // out_type[1:0]
    input  logic [1:0]                         m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [ccc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    output int                                 pending,
    output int                                 mismatches
);
    import ccc_pkg::*;

    localparam int WIDE_SLOTS = MAX_ROWS * MAX_COLS;

    cfg_t        cfg;
    logic [15:0] byte_map [BYTE_DEPTH];
    logic [15:0] wide_map [WIDE_SLOTS];
    logic [17:0] ovr_src [MAX_OVERRIDES];
    logic [17:0] ovr_dst [MAX_OVERRIDES];
    int          ovr_count;
    result_t     expected_codes [$];
    result_t     got;
    result_t     want;

    function automatic tag_t fold_tag(input logic [1:0] t);
        return (t > TAG_ERR) ? TAG_ERR : tag_t'(t);
    endfunction

    function automatic bit wide_slot(input logic [15:0] code, output int slot);
        int lead;
        int trail;
        int row;
        int col;
        lead  = code[15:8];
        trail = code[7:0];
        if (lead < cfg.lead_low || lead > cfg.lead_high) return 1'b0;
        if (trail < cfg.trail_low || trail > cfg.trail_high) return 1'b0;
        row = lead - cfg.lead_low;
        col = trail - cfg.trail_low;
        if (row >= MAX_ROWS || col >= MAX_COLS) return 1'b0;
        slot = row * MAX_COLS + col;
        return 1'b1;
    endfunction

    // Applies one item to the shadow tables and returns the result it yields.
    function automatic result_t apply_item(input logic [2:0] cmd, input logic [1:0] itype,
                                           input logic [15:0] val, input logic cjk,
                                           input logic [1:0] mtype, input logic [15:0] mval);
        result_t     r;
        tag_t        tag;
        tag_t        mtag;
        logic [15:0] hit;
        bit          ok;
        bit          found;
        int          slot;
        r     = '{out_type: TAG_B8, out_value: 16'h0000, status: ST_OK};
        tag   = fold_tag(itype);
        mtag  = fold_tag(mtype);
        found = 1'b0;
        case (cmd)
            CMD_CONVERT: begin
                for (int i = 0; i < ovr_count; i++) begin
                    if (!found && ovr_src[i] == {tag, val}) begin
                        found       = 1'b1;
                        r.out_type  = tag_t'(ovr_dst[i][17:16]);
                        r.out_value = ovr_dst[i][15:0];
                    end
                end
                if (!found) begin
                    hit = cfg.missing_marker;
                    ok  = 1'b1;
                    if (tag == TAG_B8 && !cjk) begin
                        if (val > 16'h00ff) ok = 1'b0;
                        else hit = byte_map[val[7:0]];
                    end else if (tag == TAG_WIDE) begin
                        if (wide_slot(val, slot)) hit = wide_map[slot];
                        else ok = 1'b0;
                    end
                    if (!ok || hit == cfg.missing_marker) begin
                        r.out_type  = TAG_ERR;
                        r.out_value = 16'h0000;
                    end else begin
                        r.out_type  = (hit < WIDE_BASE) ? TAG_B8 : TAG_WIDE;
                        r.out_value = hit;
                    end
                end
            end
            CMD_WR_BYTE: begin
                if (val > 16'h00ff) r.status = ST_RANGE;
                else byte_map[val[7:0]] = mval;
            end
            CMD_WR_WIDE: begin
                if (wide_slot(val, slot)) wide_map[slot] = mval;
                else r.status = ST_RANGE;
            end
            CMD_ADD_OVR: begin
                if (ovr_count >= MAX_OVERRIDES) begin
                    r.status = ST_FULL;
                end else begin
                    ovr_src[ovr_count] = {tag, val};
                    ovr_dst[ovr_count] = {mtag, mval};
                    ovr_count++;
                end
            end
            CMD_CLR_OVR: ovr_count = 0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag(input string msg);
        if (mismatches < 10) $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg = '{8'h00, 8'hff, 8'h00, 8'hff, MISSING_RESET};
            for (int i = 0; i < BYTE_DEPTH; i++) byte_map[i] = MISSING_RESET;
            for (int i = 0; i < WIDE_SLOTS; i++) wide_map[i] = MISSING_RESET;
            ovr_count  = 0;
            mismatches = 0;
            expected_codes.delete();
            pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LEAD_LOW:   cfg.lead_low       = cfg_wr_data[7:0];
                    CFG_LEAD_HIGH:  cfg.lead_high      = cfg_wr_data[7:0];
                    CFG_TRAIL_LOW:  cfg.trail_low      = cfg_wr_data[7:0];
                    CFG_TRAIL_HIGH: cfg.trail_high     = cfg_wr_data[7:0];
                    CFG_MISSING:    cfg.missing_marker = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.out_type  = tag_t'(m_tuser);
                got.out_value = m_tdata[15:0];
                got.status    = status_t'(m_tdata[17:16]);
                if (expected_codes.size() == 0) begin
                    flag($sformatf("unexpected item type %0d value %h status %0d",
                                   got.out_type, got.out_value, got.status));
                end else begin
                    want = expected_codes.pop_front();
                    if (got.out_type !== want.out_type || got.out_value !== want.out_value ||
                        got.status !== want.status)
                        flag($sformatf("exp type %0d value %h status %0d, got %0d %h %0d",
                                       want.out_type, want.out_value, want.status,
                                       got.out_type, got.out_value, got.status));
                end
            end
            if (s_tvalid && s_tready)
                expected_codes.insert(expected_codes.size(),
                                      apply_item(s_tdata[2:0], s_tuser[1:0], s_tdata[18:3],
                                                 s_tdata[19], s_tuser[3:2], s_tdata[35:20]));
            pending <= expected_codes.size();
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench top for the charset code converter: reset, stimulus, flow control and verdict.
module tb;
    import ccc_pkg::*;

    localparam int MAX_OVERRIDES = 16;
    localparam int MAX_ROWS      = 128;
    localparam int MAX_COLS      = 256;
    localparam int PHASE_ITEMS   = 175;

    localparam logic [1:0] TAG_THREE    = 2'd3;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata     = '0;
    logic [3:0]            s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [23:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int          pending;
    int          mismatches;
    int          src_pct   = 0;
    int          sink_pct  = 0;
    int          items_sent = 0;
    int          goal;
    int          waited;
    cfg_t        active_cfg = '{8'h00, 8'hff, 8'h00, 8'hff, MISSING_RESET};
    cfg_t        settings [8];
    logic [17:0] recent_keys [$];

    charset_code_converter_top #(
        .MAX_OVERRIDES(MAX_OVERRIDES), .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)
    ) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    charset_code_checker #(
        .MAX_OVERRIDES(MAX_OVERRIDES), .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)
    ) result_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .pending(pending), .mismatches(mismatches)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_pct);
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(input logic [2:0] cmd, input logic [1:0] itype,
                             input logic [15:0] ival, input logic cjk,
                             input logic [1:0] mtype, input logic [15:0] mval);
        while ($urandom_range(99) < src_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, mval, cjk, ival, cmd};
        s_tuser  <= {mtype, itype};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input cfg_t s);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
        write_reg(CFG_LEAD_LOW, {8'h00, s.lead_low});
        write_reg(CFG_LEAD_HIGH, {8'h00, s.lead_high});
        write_reg(CFG_TRAIL_LOW, {8'h00, s.trail_low});
        write_reg(CFG_TRAIL_HIGH, {8'h00, s.trail_high});
        write_reg(CFG_MISSING, s.missing_marker);
        cfg_wr_en  <= 1'b0;
        active_cfg = s;
    endtask

    function automatic logic [15:0] table_data();
        case ($urandom_range(3))
            0: return 16'($urandom_range(255));
            1: return 16'($urandom_range(16'hffff, 16'h0100));
            2: return active_cfg.missing_marker;
            default: return $urandom_range(1) ? 16'hffff : 16'h0100;
        endcase
    endfunction

    function automatic logic [15:0] byte_code();
        if ($urandom_range(6) == 0) return 16'($urandom_range(16'hffff, 16'h0100));
        return 16'($urandom_range(255));
    endfunction

    // Mostly codes inside the configured lead/trail window, usually within the row limit.
    function automatic logic [15:0] wide_code();
        int lo;
        int hi;
        logic [7:0] lead;
        logic [7:0] trail;
        if ($urandom_range(4) == 0 || active_cfg.lead_low > active_cfg.lead_high ||
            active_cfg.trail_low > active_cfg.trail_high)
            return 16'($urandom());
        lo = active_cfg.lead_low;
        hi = active_cfg.lead_high;
        if ($urandom_range(4) != 0 && lo + MAX_ROWS - 1 < hi) hi = lo + MAX_ROWS - 1;
        lead  = 8'($urandom_range(hi, lo));
        trail = 8'($urandom_range(active_cfg.trail_high, active_cfg.trail_low));
        return {lead, trail};
    endfunction

    function automatic logic [17:0] some_key();
        int r;
        if (recent_keys.size() > 0 && $urandom_range(1))
            return recent_keys[$urandom_range(recent_keys.size() - 1)];
        r = $urandom_range(9);
        if (r < 4) return {TAG_B8, byte_code()};
        if (r < 8) return {TAG_WIDE, wide_code()};
        if (r == 8) return {TAG_ERR, byte_code()};
        return {TAG_THREE, 16'($urandom())};
    endfunction

    task automatic remember(input logic [17:0] key);
        recent_keys.insert(recent_keys.size(), key);
        if (recent_keys.size() > 24) void'(recent_keys.pop_front());
    endtask

    task automatic convert_key(input logic [17:0] key);
        send_item(CMD_CONVERT, key[17:16], key[15:0], $urandom_range(5) == 0,
                  2'($urandom_range(3)), 16'($urandom()));
    endtask

    task automatic run_phase();
        logic [17:0] key;
        int          pick;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_item(3'($urandom_range(7)), 2'($urandom_range(3)), 16'($urandom()),
                          1'($urandom_range(1)), 2'($urandom_range(3)), 16'($urandom()));
            end else if (pick < 40) begin
                if ($urandom_range(1)) begin
                    key = {TAG_B8, byte_code()};
                    send_item(CMD_WR_BYTE, 2'($urandom_range(3)), key[15:0],
                              1'($urandom_range(1)), 2'($urandom_range(3)), table_data());
                end else begin
                    key = {TAG_WIDE, wide_code()};
                    send_item(CMD_WR_WIDE, 2'($urandom_range(3)), key[15:0],
                              1'($urandom_range(1)), 2'($urandom_range(3)), table_data());
                end
                remember(key);
                repeat ($urandom_range(3, 1)) convert_key(key);
            end else if (pick < 55) begin
                if ($urandom_range(1))
                    send_item(CMD_CLR_OVR, 2'($urandom_range(3)), 16'($urandom()),
                              1'($urandom_range(1)), 2'($urandom_range(3)), 16'($urandom()));
                repeat (($urandom_range(2) == 0) ? $urandom_range(20, 14) : $urandom_range(5, 1))
                begin
                    key = some_key();
                    remember(key);
                    send_item(CMD_ADD_OVR, key[17:16], key[15:0], 1'($urandom_range(1)),
                              2'($urandom_range(3)), table_data());
                end
                repeat ($urandom_range(6, 2)) convert_key(some_key());
            end else begin
                convert_key(some_key());
            end
        end
    endtask

    initial begin
        settings[0] = '{8'h00, 8'hff, 8'h00, 8'hff, 16'hfffd};
        settings[1] = '{8'h81, 8'hfe, 8'h40, 8'hfe, 16'hfffd};
        settings[2] = '{8'h00, 8'h7f, 8'h00, 8'hff, 16'h0000};
        settings[3] = '{8'hff, 8'hff, 8'hff, 8'hff, 16'hffff};
        settings[4] = '{8'ha1, 8'hfe, 8'ha1, 8'hfe, 16'hfffd};
        settings[5] = '{8'h80, 8'h10, 8'h00, 8'hff, 16'hfffd};
        settings[6] = '{8'h00, 8'h00, 8'h00, 8'h00, 16'h0061};
        settings[7] = '{8'h20, 8'hff, 8'h01, 8'h80, 16'hfffd};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: lead 0..255 but only 128 rows, so leads from 0x80 fall outside
        send_item(CMD_CONVERT, TAG_B8, 16'h0041, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_WR_BYTE, TAG_B8, 16'h0041, 1'b0, TAG_B8, 16'h0061);
        send_item(CMD_CONVERT, TAG_B8, 16'h0041, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_WR_BYTE, TAG_B8, 16'h00ff, 1'b0, TAG_B8, 16'h1234);
        send_item(CMD_CONVERT, TAG_B8, 16'h00ff, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_CONVERT, TAG_B8, 16'h00ff, 1'b1, TAG_B8, 16'h0000);
        send_item(CMD_WR_BYTE, TAG_B8, 16'h0100, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_CONVERT, TAG_B8, 16'hffff, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_WR_WIDE, TAG_WIDE, 16'h7fff, 1'b0, TAG_B8, 16'hffff);
        send_item(CMD_CONVERT, TAG_WIDE, 16'h7fff, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_WR_WIDE, TAG_WIDE, 16'h0000, 1'b0, TAG_B8, 16'h00ff);
        send_item(CMD_CONVERT, TAG_WIDE, 16'h0000, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_WR_WIDE, TAG_WIDE, 16'h8000, 1'b0, TAG_B8, 16'h0001);
        send_item(CMD_CONVERT, TAG_WIDE, 16'hffff, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_CONVERT, TAG_ERR, 16'h0041, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_ADD_OVR, TAG_THREE, 16'h0041, 1'b0, TAG_THREE, 16'habcd);
        send_item(CMD_CONVERT, TAG_ERR, 16'h0041, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_ADD_OVR, TAG_B8, 16'h0041, 1'b0, TAG_WIDE, 16'h5555);
        send_item(CMD_ADD_OVR, TAG_B8, 16'h0041, 1'b0, TAG_B8, 16'h0001);
        send_item(CMD_CONVERT, TAG_B8, 16'h0041, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_CLR_OVR, TAG_B8, 16'h0000, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_CONVERT, TAG_B8, 16'h0041, 1'b0, TAG_B8, 16'h0000);
        send_item(CMD_SPARE_LO, TAG_WIDE, 16'hffff, 1'b1, TAG_THREE, 16'hffff);
        send_item(CMD_SPARE_HI, TAG_THREE, 16'h0041, 1'b0, TAG_WIDE, 16'h1234);

        goal = items_sent;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin src_pct = 0;  sink_pct = 0;  end
                1: begin src_pct = 73; sink_pct = 0;  end
                2: begin src_pct = 0;  sink_pct = 73; end
                default: begin src_pct = 20; sink_pct = 20; end
            endcase
            apply_settings(settings[phase]);
            recent_keys.delete();
            goal += PHASE_ITEMS;
            run_phase();
        end
        s_tvalid <= 1'b0;

        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (pending != 0 && waited < 20000);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/ccc_pkg.sv
sv/ccc_ram.sv
sv/ccc_queue.sv
sv/ccc_front.sv
sv/ccc_back.sv
sv/charset_code_converter_top.sv
sim/charset_code_checker.sv
sim/tb.sv
